// ===== rtl/pcr_pkg.sv =====
// Shared widths, reset values and register codes for the particle contact resolver.
// No dependencies; imported by the resolver, its divider pipeline and its checker.
package pcr_pkg;

  localparam int MASS_W     = 24;  // inverse mass, unsigned Q8.16
  localparam int TOT_W      = 25;  // sum of two inverse masses
  localparam int RES_W      = 17;  // restitution, unsigned Q1.16
  localparam int DT_W       = 16;  // time step, unsigned Q0.16
  localparam int PEN_W      = 21;  // penetration, signed Q8.12
  localparam int CFG_DATA_W = 17;
  localparam int FRAC_SH    = 16;  // drop of Q0.16 scale factors
  localparam int DELTA_SH   = 8;   // Q.24 velocity change to Q.16
  localparam int PEN_SH     = 8;   // penetration Q.12 to Q.20
  localparam int MOVE_SH    = 20;  // position product back to Q.12

  localparam logic [RES_W-1:0] RES_RESET = RES_W'(65536);
  localparam logic [DT_W-1:0]  DT_RESET  = DT_W'(1092);

  typedef enum logic [0:0] {
    CFG_RESTITUTION = 1'b0,
    CFG_TIME_STEP   = 1'b1
  } cfg_reg_e;

endpackage

// ===== rtl/pcr_div.sv =====
// Pipelined restoring divider, two lanes over one divisor, one quotient bit per stage.
// Depends on pcr_pkg for the mass widths.
module pcr_div #(
  parameter int QW     = 38,
  parameter int SIDE_W = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [QW+pcr_pkg::MASS_W-1:0]     num_a_i,
  input  logic [QW+pcr_pkg::MASS_W-1:0]     num_b_i,
  input  logic [pcr_pkg::TOT_W-1:0]         den_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic [QW-1:0]                     quo_a_o,
  output logic [QW-1:0]                     quo_b_o,
  output logic                              rem_a_nz_o,
  output logic                              rem_b_nz_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import pcr_pkg::*;

  localparam int RW = TOT_W;

  logic [RW-1:0]     rem_a_q  [QW];
  logic [RW-1:0]     rem_b_q  [QW];
  logic [QW-1:0]     low_a_q  [QW];
  logic [QW-1:0]     low_b_q  [QW];
  logic [RW-1:0]     den_q    [QW];
  logic [SIDE_W-1:0] side_q   [QW];
  logic              vld_q    [QW];

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  function automatic logic [RW+QW-1:0] div_step(input logic [RW-1:0] rem,
                                                input logic [QW-1:0] low,
                                                input logic [RW-1:0] den);
    logic [RW:0] t;
    logic [RW:0] diff;
    logic        ge;
    t    = {rem, low[QW-1]};
    diff = t - {1'b0, den};
    ge   = (t >= {1'b0, den});
    div_step = {(ge ? diff[RW-1:0] : t[RW-1:0]), low[QW-2:0], ge};
  endfunction

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [RW-1:0]     rem_a_in, rem_b_in, den_in;
    logic [QW-1:0]     low_a_in, low_b_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (j == 0) begin : g_first
      // Upper dividend bits are already below the divisor.
      assign rem_a_in = RW'(num_a_i[QW+MASS_W-1:QW]);
      assign rem_b_in = RW'(num_b_i[QW+MASS_W-1:QW]);
      assign low_a_in = num_a_i[QW-1:0];
      assign low_b_in = num_b_i[QW-1:0];
      assign den_in   = den_i;
      assign side_in  = side_i;
      assign vld_in   = valid_i;
    end else begin : g_next
      assign rem_a_in = rem_a_q[j-1];
      assign rem_b_in = rem_b_q[j-1];
      assign low_a_in = low_a_q[j-1];
      assign low_b_in = low_b_q[j-1];
      assign den_in   = den_q[j-1];
      assign side_in  = side_q[j-1];
      assign vld_in   = vld_q[j-1];
    end

    // Advance the valid bit.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end

    // Advance the partial remainders and quotients.
    always_ff @(posedge clk_i) begin
      {rem_a_q[j], low_a_q[j]} <= div_step(rem_a_in, low_a_in, den_in);
      {rem_b_q[j], low_b_q[j]} <= div_step(rem_b_in, low_b_in, den_in);
      den_q[j]                 <= den_in;
      side_q[j]                <= side_in;
    end
  end

  assign valid_o    = vld_q[QW-1];
  assign quo_a_o    = low_a_q[QW-1];
  assign quo_b_o    = low_b_q[QW-1];
  assign rem_a_nz_o = |rem_a_q[QW-1];
  assign rem_b_nz_o = |rem_b_q[QW-1];
  assign side_o     = side_q[QW-1];

endmodule

// ===== rtl/particle_contact_resolver.sv =====
// Particle contact resolver: impulse and penetration sharing for one contact per cycle.
// Depends on pcr_pkg and the divider pipeline pcr_div.
//
// Usage:
//   A request enters at a rising edge with start high and busy low; busy stays low,
//   so a new contact can enter on every cycle. Each request produces exactly one
//   result, shown on the result ports for one cycle with done_o high.
//   Throughput is one per cycle. Six arithmetic stages lead into a restoring divider
//   of 2*COMP_WIDTH-4 stages, one quotient bit each, which sets the depth; three
//   stages then apply the shares to the normal and saturate.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i selecting restitution
//   or time step; ready is always high. Write only while no request is in flight.
//   Reset clears all valid bits and loads restitution 1.0 and time step 1092.
//   The receiver cannot stall: results leave on the cycle they are done.
module particle_contact_resolver #(
  parameter int COMP_WIDTH = 21
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  pcr_pkg::cfg_reg_e                 cfg_index_i,
  input  logic [pcr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [3*COMP_WIDTH-1:0]           first_velocity_i,
  input  logic [3*COMP_WIDTH-1:0]           second_velocity_i,
  input  logic [3*COMP_WIDTH-1:0]           first_accel_i,
  input  logic [3*COMP_WIDTH-1:0]           second_accel_i,
  input  logic [3*COMP_WIDTH-1:0]           contact_normal_i,
  input  logic [pcr_pkg::MASS_W-1:0]        first_inv_mass_i,
  input  logic [pcr_pkg::MASS_W-1:0]        second_inv_mass_i,
  input  logic                              has_second_i,
  input  logic signed [pcr_pkg::PEN_W-1:0]  penetration_i,
  output logic                              done_o,
  output logic [3*COMP_WIDTH-1:0]           first_new_velocity_o,
  output logic [3*COMP_WIDTH-1:0]           second_new_velocity_o,
  output logic [3*COMP_WIDTH-1:0]           first_move_o,
  output logic [3*COMP_WIDTH-1:0]           second_move_o,
  output logic                              impulse_applied_o,
  output logic                              moved_o
);
  import pcr_pkg::*;

  localparam int W  = COMP_WIDTH;
  localparam int VW = 3 * W;
  localparam int PW = 2 * W + 1;   // component product
  localparam int SW = 2 * W + 3;   // dot product
  localparam int CW = 2 * W + 2;   // closing speed magnitude
  localparam int DW = 2 * W - 4;   // velocity change, Q.16
  localparam int NW = DW + MASS_W; // dividend
  localparam int MW = W + DW;      // normal times share
  localparam int XW = MW - FRAC_SH;
  localparam int YW = MW - MOVE_SH;
  localparam int RW = XW + 2;

  typedef struct packed {
    logic [VW-1:0] v0;
    logic [VW-1:0] v1;
    logic [VW-1:0] n;
    logic          has;
  } carry_t;

  localparam int SIDE_W = 2 * DW + $bits(carry_t) + 2;

  // Saturate to the signed component range.
  function automatic logic [W-1:0] sat(input logic [RW-1:0] x);
    logic fits;
    fits = (&x[RW-1:W-1]) || !(|x[RW-1:W-1]);
    if (fits) begin
      sat = x[W-1:0];
    end else if (x[RW-1]) begin
      sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  logic [RES_W-1:0] rest_q;
  logic [DT_W-1:0]  dt_q;
  logic             accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Hold the configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= RES_RESET;
      dt_q   <= DT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RESTITUTION: rest_q <= cfg_data_i[RES_W-1:0];
        CFG_TIME_STEP:   dt_q   <= cfg_data_i[DT_W-1:0];
        default:         rest_q <= rest_q;
      endcase
    end
  end

  // ---------------- stage 1: relative vectors times normal
  logic signed [PW-1:0] pv_c [3];
  logic signed [PW-1:0] pa_c [3];
  carry_t               c1_c;
  logic [TOT_W-1:0]     tot_c;

  always_comb begin
    logic signed [W-1:0] v0, v1, a0, a1, nk;
    logic signed [W:0]   dv, da;
    c1_c.v0  = first_velocity_i;
    c1_c.v1  = has_second_i ? second_velocity_i : '0;
    c1_c.n   = contact_normal_i;
    c1_c.has = has_second_i;
    for (int k = 0; k < 3; k++) begin
      v0 = first_velocity_i[k*W +: W];
      v1 = has_second_i ? second_velocity_i[k*W +: W] : '0;
      a0 = first_accel_i[k*W +: W];
      a1 = has_second_i ? second_accel_i[k*W +: W] : '0;
      nk = contact_normal_i[k*W +: W];
      dv = {v0[W-1], v0} - {v1[W-1], v1};
      da = {a0[W-1], a0} - {a1[W-1], a1};
      pv_c[k] = PW'(dv) * PW'(nk);
      pa_c[k] = PW'(da) * PW'(nk);
    end
    tot_c = TOT_W'(first_inv_mass_i)
          + (has_second_i ? TOT_W'(second_inv_mass_i) : '0);
  end

  logic                    s1_vld_q;
  carry_t                  s1_c_q;
  logic signed [PW-1:0]    s1_pv_q [3];
  logic signed [PW-1:0]    s1_pa_q [3];
  logic [MASS_W-1:0]       s1_m1_q;
  logic [TOT_W-1:0]        s1_tot_q;
  logic signed [PEN_W-1:0] s1_pen_q;

  always_ff @(posedge clk_i) begin
    s1_c_q   <= c1_c;
    s1_pv_q  <= pv_c;
    s1_pa_q  <= pa_c;
    s1_m1_q  <= first_inv_mass_i;
    s1_tot_q <= tot_c;
    s1_pen_q <= penetration_i;
  end

  // ---------------- stage 2: dot products
  logic                    s2_vld_q;
  carry_t                  s2_c_q;
  logic signed [SW-1:0]    s2_sep_q, s2_ad_q;
  logic [MASS_W-1:0]       s2_m1_q;
  logic [TOT_W-1:0]        s2_tot_q;
  logic signed [PEN_W-1:0] s2_pen_q;

  always_ff @(posedge clk_i) begin
    s2_c_q   <= s1_c_q;
    s2_sep_q <= SW'(s1_pv_q[0]) + SW'(s1_pv_q[1]) + SW'(s1_pv_q[2]);
    s2_ad_q  <= SW'(s1_pa_q[0]) + SW'(s1_pa_q[1]) + SW'(s1_pa_q[2]);
    s2_m1_q  <= s1_m1_q;
    s2_tot_q <= s1_tot_q;
    s2_pen_q <= s1_pen_q;
  end

  // ---------------- stage 3: restitution and acceleration build-up
  logic                  imp_c, mv_c;
  logic [CW-1:0]         closing_c, accin_c;
  logic [CW+RES_W-1:0]   nprod_c;
  logic [CW+DT_W-1:0]    aprod_c;
  logic [DW-1:0]         p_c;

  always_comb begin
    logic [SW-1:0] negsep, negad;
    negsep    = -s2_sep_q;
    negad     = -s2_ad_q;
    imp_c     = (s2_sep_q <= 0) && (s2_tot_q != '0);
    mv_c      = (s2_pen_q > 0) && (s2_tot_q != '0);
    closing_c = imp_c ? negsep[CW-1:0] : '0;
    accin_c   = s2_ad_q[SW-1] ? negad[CW-1:0] : '0;
    nprod_c   = (CW+RES_W)'(closing_c) * (CW+RES_W)'(rest_q);
    aprod_c   = (CW+DT_W)'(accin_c) * (CW+DT_W)'(dt_q);
    p_c       = mv_c ? (DW'(s2_pen_q[PEN_W-2:0]) << PEN_SH) : '0;
  end

  logic               s3_vld_q;
  carry_t             s3_c_q;
  logic [CW-1:0]      s3_closing_q, s3_accm_q;
  logic [CW:0]        s3_nsep_q;
  logic [DW-1:0]      s3_p_q;
  logic [MASS_W-1:0]  s3_m1_q;
  logic [TOT_W-1:0]   s3_tot_q;
  logic               s3_imp_q, s3_mv_q;

  always_ff @(posedge clk_i) begin
    s3_c_q       <= s2_c_q;
    s3_closing_q <= closing_c;
    s3_nsep_q    <= nprod_c[CW+RES_W-1:FRAC_SH];
    s3_accm_q    <= aprod_c[CW+DT_W-1:FRAC_SH];
    s3_p_q       <= p_c;
    s3_m1_q      <= s2_m1_q;
    s3_tot_q     <= s2_tot_q;
    s3_imp_q     <= imp_c;
    s3_mv_q      <= mv_c;
  end

  // ---------------- stage 4: scale the acceleration term by restitution
  logic [CW+RES_W-1:0] rprod_c;
  assign rprod_c = (CW+RES_W)'(s3_accm_q) * (CW+RES_W)'(rest_q);

  logic               s4_vld_q;
  carry_t             s4_c_q;
  logic [CW-1:0]      s4_closing_q;
  logic [CW:0]        s4_nsep_q, s4_red_q;
  logic [DW-1:0]      s4_p_q;
  logic [MASS_W-1:0]  s4_m1_q;
  logic [TOT_W-1:0]   s4_tot_q;
  logic               s4_imp_q, s4_mv_q;

  always_ff @(posedge clk_i) begin
    s4_c_q       <= s3_c_q;
    s4_closing_q <= s3_closing_q;
    s4_nsep_q    <= s3_nsep_q;
    s4_red_q     <= rprod_c[CW+RES_W-1:FRAC_SH];
    s4_p_q       <= s3_p_q;
    s4_m1_q      <= s3_m1_q;
    s4_tot_q     <= s3_tot_q;
    s4_imp_q     <= s3_imp_q;
    s4_mv_q      <= s3_mv_q;
  end

  // ---------------- stage 5: clamp and form the velocity change
  logic [CW:0]   nsep2_c;
  logic [CW+1:0] dsum_c;

  always_comb begin
    nsep2_c = (s4_red_q >= s4_nsep_q) ? '0 : (s4_nsep_q - s4_red_q);
    dsum_c  = (CW+2)'(nsep2_c) + (CW+2)'(s4_closing_q);
  end

  logic               s5_vld_q;
  carry_t             s5_c_q;
  logic [DW-1:0]      s5_d_q, s5_p_q;
  logic [MASS_W-1:0]  s5_m1_q;
  logic [TOT_W-1:0]   s5_tot_q;
  logic               s5_imp_q, s5_mv_q;

  always_ff @(posedge clk_i) begin
    s5_c_q   <= s4_c_q;
    s5_d_q   <= dsum_c[CW+1:DELTA_SH];
    s5_p_q   <= s4_p_q;
    s5_m1_q  <= s4_m1_q;
    s5_tot_q <= s4_tot_q;
    s5_imp_q <= s4_imp_q;
    s5_mv_q  <= s4_mv_q;
  end

  // ---------------- stage 6: dividends for the mass shares
  logic              s6_vld_q;
  logic [NW-1:0]     s6_num_a_q, s6_num_b_q;
  logic [TOT_W-1:0]  s6_den_q;
  logic [SIDE_W-1:0] s6_side_q;

  always_ff @(posedge clk_i) begin
    s6_num_a_q <= NW'(s5_d_q) * NW'(s5_m1_q);
    s6_num_b_q <= NW'(s5_p_q) * NW'(s5_m1_q);
    // A zero total only occurs with zero dividends; keep the divisor nonzero.
    s6_den_q   <= (s5_tot_q == '0) ? TOT_W'(1) : s5_tot_q;
    s6_side_q  <= {s5_d_q, s5_p_q, s5_c_q, s5_imp_q, s5_mv_q};
  end

  // ---------------- divider pipeline
  logic              div_vld;
  logic [DW-1:0]     div_qa, div_qb;
  logic              div_ra_nz, div_rb_nz;
  logic [SIDE_W-1:0] div_side;

  pcr_div #(
    .QW     (DW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s6_vld_q),
    .num_a_i    (s6_num_a_q),
    .num_b_i    (s6_num_b_q),
    .den_i      (s6_den_q),
    .side_i     (s6_side_q),
    .valid_o    (div_vld),
    .quo_a_o    (div_qa),
    .quo_b_o    (div_qb),
    .rem_a_nz_o (div_ra_nz),
    .rem_b_nz_o (div_rb_nz),
    .side_o     (div_side)
  );

  // ---------------- stage 7: second share from the first (floor of the complement)
  logic [DW-1:0] dd_c, dp_c;
  carry_t        c7_c;
  logic          imp7_c, mv7_c;

  assign {dd_c, dp_c, c7_c, imp7_c, mv7_c} = div_side;

  logic          s7_vld_q;
  carry_t        s7_c_q;
  logic [DW-1:0] s7_w0_q, s7_w1_q, s7_pw0_q, s7_pw1_q;
  logic          s7_imp_q, s7_mv_q;

  always_ff @(posedge clk_i) begin
    s7_c_q   <= c7_c;
    s7_w0_q  <= div_qa;
    s7_w1_q  <= dd_c - div_qa - DW'(div_ra_nz);
    s7_pw0_q <= div_qb;
    s7_pw1_q <= dp_c - div_qb - DW'(div_rb_nz);
    s7_imp_q <= imp7_c;
    s7_mv_q  <= mv7_c;
  end

  // ---------------- stage 8: normal magnitudes times shares
  logic [MW-1:0] x0_c [3];
  logic [MW-1:0] x1_c [3];
  logic [MW-1:0] y0_c [3];
  logic [MW-1:0] y1_c [3];

  always_comb begin
    logic [W-1:0] nk, nm;
    for (int k = 0; k < 3; k++) begin
      nk      = s7_c_q.n[k*W +: W];
      nm      = nk[W-1] ? -nk : nk;
      x0_c[k] = MW'(nm) * MW'(s7_w0_q);
      x1_c[k] = MW'(nm) * MW'(s7_w1_q);
      y0_c[k] = MW'(nm) * MW'(s7_pw0_q);
      y1_c[k] = MW'(nm) * MW'(s7_pw1_q);
    end
  end

  logic          s8_vld_q;
  carry_t        s8_c_q;
  logic [MW-1:0] s8_x0_q [3];
  logic [MW-1:0] s8_x1_q [3];
  logic [MW-1:0] s8_y0_q [3];
  logic [MW-1:0] s8_y1_q [3];
  logic          s8_imp_q, s8_mv_q;

  always_ff @(posedge clk_i) begin
    s8_c_q   <= s7_c_q;
    s8_x0_q  <= x0_c;
    s8_x1_q  <= x1_c;
    s8_y0_q  <= y0_c;
    s8_y1_q  <= y1_c;
    s8_imp_q <= s7_imp_q;
    s8_mv_q  <= s7_mv_q;
  end

  // ---------------- stage 9: apply signs, add, saturate, pack
  logic [VW-1:0] r0_c, r1_c, p0_c, p1_c;

  always_comb begin
    logic          neg;
    logic [RW-1:0] t0, t1, u0, u1, v0, v1;
    for (int k = 0; k < 3; k++) begin
      neg = s8_c_q.n[k*W + W - 1];
      t0  = RW'(s8_x0_q[k][MW-1:FRAC_SH]);
      t1  = RW'(s8_x1_q[k][MW-1:FRAC_SH]);
      u0  = RW'(s8_y0_q[k][MW-1:MOVE_SH]);
      u1  = RW'(s8_y1_q[k][MW-1:MOVE_SH]);
      v0  = RW'(signed'(s8_c_q.v0[k*W +: W]));
      v1  = RW'(signed'(s8_c_q.v1[k*W +: W]));
      r0_c[k*W +: W] = sat(neg ? (v0 - t0) : (v0 + t0));
      r1_c[k*W +: W] = sat(neg ? (v1 + t1) : (v1 - t1));
      p0_c[k*W +: W] = sat(neg ? -u0 : u0);
      p1_c[k*W +: W] = sat(neg ? u1 : -u1);
    end
  end

  always_ff @(posedge clk_i) begin
    first_new_velocity_o  <= r0_c;
    second_new_velocity_o <= s8_c_q.has ? r1_c : '0;
    first_move_o          <= p0_c;
    second_move_o         <= s8_c_q.has ? p1_c : '0;
    impulse_applied_o     <= s8_imp_q;
    moved_o               <= s8_mv_q;
  end

  // Advance the valid bits along the arithmetic stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= div_vld;
      s8_vld_q <= s7_vld_q;
      done_o   <= s8_vld_q;
    end
  end

endmodule

// ===== rtl/pcr_checker.sv =====
// Port-level checks for the particle contact resolver, attached by bind.
// Depends on pcr_pkg; watches only the top-level ports.
module pcr_checker #(
  parameter int COMP_WIDTH = 21
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input pcr_pkg::cfg_reg_e                 cfg_index_i,
  input logic [pcr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input logic [3*COMP_WIDTH-1:0]           first_velocity_i,
  input logic [3*COMP_WIDTH-1:0]           second_velocity_i,
  input logic [3*COMP_WIDTH-1:0]           first_accel_i,
  input logic [3*COMP_WIDTH-1:0]           second_accel_i,
  input logic [3*COMP_WIDTH-1:0]           contact_normal_i,
  input logic [pcr_pkg::MASS_W-1:0]        first_inv_mass_i,
  input logic [pcr_pkg::MASS_W-1:0]        second_inv_mass_i,
  input logic                              has_second_i,
  input logic signed [pcr_pkg::PEN_W-1:0]  penetration_i,
  input logic                              done_o,
  input logic [3*COMP_WIDTH-1:0]           first_new_velocity_o,
  input logic [3*COMP_WIDTH-1:0]           second_new_velocity_o,
  input logic [3*COMP_WIDTH-1:0]           first_move_o,
  input logic [3*COMP_WIDTH-1:0]           second_move_o,
  input logic                              impulse_applied_o,
  input logic                              moved_o
);
  import pcr_pkg::*;

  localparam int LAT   = 2 * COMP_WIDTH + 5;
  localparam int CNT_W = $clog2(LAT + 1);

  logic [CNT_W-1:0] warm_q;
  logic             warm;

  // Count cycles since reset until the pipeline has filled once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (warm_q != CNT_W'(LAT)) begin
      warm_q <= warm_q + CNT_W'(1);
    end
  end

  assign warm = (warm_q == CNT_W'(LAT));

  // Every request yields one result after the fixed latency, and nothing else.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (done_o == $past(start && !busy, LAT)))
    else $error("result strobe does not match request latency");

  // No second particle: its outputs are zero.
  a_no_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o && !$past(has_second_i, LAT)) |->
      (second_new_velocity_o == '0) && (second_move_o == '0))
    else $error("second particle outputs not zero when absent");

  // Without correction, both moves are zero.
  a_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !moved_o) |-> (first_move_o == '0) && (second_move_o == '0))
    else $error("position correction without moved flag");

  // Without impulse, the first velocity passes through.
  a_no_impulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o && !impulse_applied_o) |->
      (first_new_velocity_o == $past(first_velocity_i, LAT)))
    else $error("velocity changed without impulse");

endmodule

bind particle_contact_resolver pcr_checker #(.COMP_WIDTH(COMP_WIDTH)) u_pcr_checker (.*);

// ===== tb/sv/tb_particle_contact_resolver.sv =====
// Self-checking testbench for particle_contact_resolver: drives contacts, predicts results.
// Depends on pcr_pkg and the resolver RTL; expected values come from an in-file predictor.
`timescale 1ns / 1ps

module tb_particle_contact_resolver;
  import pcr_pkg::*;

  localparam int CW = 21;
  localparam int VW = 3 * CW;
  localparam int LATENCY = 2 * CW + 5;
  localparam int N_RANDOM = 1250;
  localparam longint CMAXV = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMINV = -(64'sd1 <<< (CW - 1));

  typedef struct {
    logic [VW-1:0] v0, v1, a0, a1, n;
    logic [MASS_W-1:0] m0, m1;
    logic has;
    logic [PEN_W-1:0] pen;
  } contact_t;

  typedef struct {
    logic [VW-1:0] nv0, nv1, mv0, mv1;
    logic imp, mvd;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_reg_e cfg_index_i = CFG_RESTITUTION;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic [VW-1:0] first_velocity_i = '0, second_velocity_i = '0;
  logic [VW-1:0] first_accel_i = '0, second_accel_i = '0, contact_normal_i = '0;
  logic [MASS_W-1:0] first_inv_mass_i = '0, second_inv_mass_i = '0;
  logic has_second_i = 1'b0;
  logic signed [PEN_W-1:0] penetration_i = '0;
  logic done_o;
  logic [VW-1:0] first_new_velocity_o, second_new_velocity_o, first_move_o, second_move_o;
  logic impulse_applied_o, moved_o;

  particle_contact_resolver #(.COMP_WIDTH(CW)) u_top (.*);

  always #4 clk_i = ~clk_i;

  contact_t pending_contacts[$];
  outcome_t expected_outcomes[$];
  logic [16:0] restitution_q = 17'd65536;
  logic [15:0] time_step_q = 16'd1092;
  int errors = 0;
  int resolved = 0;
  int impulses = 0;
  int moves = 0;
  bit sender_gaps = 1'b1;
  longint cycles = 0;

  function automatic longint comp(logic [VW-1:0] w, int k);
    logic signed [CW-1:0] c;
    c = w[k*CW +: CW];
    return longint'(c);
  endfunction

  function automatic logic [VW-1:0] pack_sat(longint c[3]);
    logic [VW-1:0] w;
    longint x;
    w = '0;
    for (int k = 0; k < 3; k++) begin
      x = c[k];
      if (x > CMAXV) x = CMAXV;
      if (x < CMINV) x = CMINV;
      w[k*CW +: CW] = x[CW-1:0];
    end
    return w;
  endfunction

  // sign(a) * ((|a| * b) >> sh)
  function automatic longint scale_signed(longint a, longint unsigned b, int sh);
    longint unsigned m, r;
    m = a < 0 ? -a : a;
    r = (m * b) >> sh;
    return a < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic outcome_t resolve_contact(contact_t c);
    outcome_t o;
    longint v0[3], v1[3], a0[3], a1[3], nn[3], r0[3], r1[3], p0[3], p1[3];
    longint sep, ad, pen;
    longint unsigned mm0, mm1, total, closing, nsep, accm, red, d16, w0, w1, p;
    mm0 = c.m0;
    mm1 = c.has ? c.m1 : 0;
    total = mm0 + mm1;
    pen = longint'($signed(c.pen));
    sep = 0;
    ad = 0;
    for (int k = 0; k < 3; k++) begin
      v0[k] = comp(c.v0, k);
      v1[k] = c.has ? comp(c.v1, k) : 0;
      a0[k] = comp(c.a0, k);
      a1[k] = c.has ? comp(c.a1, k) : 0;
      nn[k] = comp(c.n, k);
      sep += (v0[k] - v1[k]) * nn[k];
      ad += (a0[k] - a1[k]) * nn[k];
      r0[k] = v0[k];
      r1[k] = v1[k];
      p0[k] = 0;
      p1[k] = 0;
    end
    o.imp = 1'b0;
    o.mvd = 1'b0;
    // closing contact: restitution minus acceleration term, clamped at zero
    if (sep <= 0 && total != 0) begin
      closing = -sep;
      nsep = (closing * restitution_q) >> 16;
      if (ad < 0) begin
        accm = (longint'(-ad) * time_step_q) >> 16;
        red = (accm * restitution_q) >> 16;
        nsep = red >= nsep ? 0 : nsep - red;
      end
      d16 = (nsep + closing) >> 8;
      w0 = d16 * mm0 / total;
      w1 = d16 * mm1 / total;
      for (int k = 0; k < 3; k++) begin
        r0[k] = v0[k] + scale_signed(nn[k], w0, 16);
        r1[k] = v1[k] - scale_signed(nn[k], w1, 16);
      end
      o.imp = 1'b1;
    end
    // penetration shared out by inverse mass
    if (pen > 0 && total != 0) begin
      p = longint'(pen) << 8;
      w0 = p * mm0 / total;
      w1 = p * mm1 / total;
      for (int k = 0; k < 3; k++) begin
        p0[k] = scale_signed(nn[k], w0, 20);
        p1[k] = -scale_signed(nn[k], w1, 20);
      end
      o.mvd = 1'b1;
    end
    o.nv0 = pack_sat(r0);
    o.nv1 = c.has ? pack_sat(r1) : '0;
    o.mv0 = pack_sat(p0);
    o.mv1 = c.has ? pack_sat(p1) : '0;
    return o;
  endfunction

  function automatic logic [VW-1:0] rand_vec(int mode);
    logic [VW-1:0] w;
    int s;
    w = VW'({$urandom, $urandom});
    if (mode == 1) begin
      // moderate magnitudes for realistic contacts
      for (int k = 0; k < 3; k++) begin
        s = $urandom_range(0, 16383) - 8192;
        w[k*CW +: CW] = CW'(s);
      end
    end
    return w;
  endfunction

  function automatic logic [VW-1:0] rand_normal();
    logic [VW-1:0] w;
    int ax, s;
    w = '0;
    ax = $urandom_range(0, 3);
    if (ax == 3) return rand_vec(1);
    s = $urandom_range(0, 1) ? 4096 : -4096;
    w[ax*CW +: CW] = CW'(s);
    return w;
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    int mode;
    mode = $urandom_range(0, 9) < 7 ? 1 : 0;
    c.v0 = rand_vec(mode);
    c.v1 = rand_vec(mode);
    c.a0 = rand_vec(mode);
    c.a1 = rand_vec(mode);
    c.n = mode ? rand_normal() : rand_vec(0);
    c.m0 = $urandom_range(0, 7) == 0 ? '0 : MASS_W'($urandom);
    c.m1 = $urandom_range(0, 7) == 0 ? '0 : MASS_W'($urandom);
    if (mode && $urandom_range(0, 1)) begin
      c.m0 = MASS_W'($urandom_range(0, 262143));
      c.m1 = MASS_W'($urandom_range(0, 262143));
    end
    c.has = 1'($urandom_range(0, 1));
    c.pen = mode ? PEN_W'($urandom_range(0, 20000) - 4000) : PEN_W'($urandom);
    return c;
  endfunction

  function automatic contact_t mk(logic [VW-1:0] v0, logic [VW-1:0] v1, logic [VW-1:0] n,
                                  logic [MASS_W-1:0] m0, logic [MASS_W-1:0] m1,
                                  logic has, logic [PEN_W-1:0] pen);
    contact_t c;
    c.v0 = v0; c.v1 = v1; c.a0 = '0; c.a1 = '0; c.n = n;
    c.m0 = m0; c.m1 = m1; c.has = has; c.pen = pen;
    return c;
  endfunction

  // Queue the directed set: extremes, separating, zero dot, zero mass, no second.
  task automatic load_directed();
    contact_t c;
    logic [VW-1:0] nz, vneg;
    nz = '0; nz[2*CW +: CW] = CW'(4096);
    vneg = '0; vneg[2*CW +: CW] = CW'(-8192);
    pending_contacts.push_back(mk(vneg, '0, nz, 24'd65536, 24'd65536, 1'b1, PEN_W'(409)));
    pending_contacts.push_back(mk(vneg, '0, nz, 24'd65536, 24'd65536, 1'b0, PEN_W'(409)));
    pending_contacts.push_back(mk(~vneg & {VW{1'b1}}, '0, nz, 24'd100, 24'd0, 1'b1,
                                  PEN_W'(-5)));
    pending_contacts.push_back(mk('0, '0, nz, 24'd65536, 24'd0, 1'b0, PEN_W'(0)));
    pending_contacts.push_back(mk(vneg, '0, nz, 24'd0, 24'd0, 1'b1, PEN_W'(1000)));
    pending_contacts.push_back(mk(vneg, '0, nz, 24'd0, 24'hFFFFFF, 1'b0, PEN_W'(1000)));
    pending_contacts.push_back(mk({VW{1'b1}}, {VW{1'b0}}, {VW{1'b1}}, 24'hFFFFFF,
                                  24'hFFFFFF, 1'b1, PEN_W'(21'h0FFFFF)));
    pending_contacts.push_back(mk({3{21'h100000}}, {3{21'h0FFFFF}}, {3{21'h100000}},
                                  24'hFFFFFF, 24'd1, 1'b1, PEN_W'(21'h100000)));
    pending_contacts.push_back(mk({3{21'h0FFFFF}}, {3{21'h100000}}, {3{21'h100000}},
                                  24'd1, 24'hFFFFFF, 1'b1, PEN_W'(21'h0FFFFF)));
    c = mk(vneg, '0, nz, 24'd65536, 24'd65536, 1'b1, PEN_W'(1));
    c.a0 = vneg; c.a1 = {3{21'h0FFFFF}};
    pending_contacts.push_back(c);
    c.a0 = {3{21'h100000}}; c.a1 = {3{21'h0FFFFF}}; c.has = 1'b0;
    pending_contacts.push_back(c);
    for (int i = 0; i < 8; i++) pending_contacts.push_back(rand_contact());
  endtask

  // Driver: present the next request at the falling edge, hold it until accepted.
  always @(negedge clk_i) begin
    contact_t c;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_outcomes.push_back(resolve_contact(pending_contacts.pop_front()));
      end
      if (pending_contacts.size() > 0 && !(sender_gaps && $urandom_range(0, 99) < 31)) begin
        c = pending_contacts[0];
        start <= 1'b1;
        first_velocity_i <= c.v0;
        second_velocity_i <= c.v1;
        first_accel_i <= c.a0;
        second_accel_i <= c.a1;
        contact_normal_i <= c.n;
        first_inv_mass_i <= c.m0;
        second_inv_mass_i <= c.m1;
        has_second_i <= c.has;
        penetration_i <= c.pen;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each done strobe with the oldest prediction.
  always @(posedge clk_i) begin
    outcome_t e;
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with no request pending", $realtime);
        errors <= errors + 1;
      end else begin
        e = expected_outcomes.pop_front();
        resolved <= resolved + 1;
        impulses <= impulses + int'(e.imp);
        moves <= moves + int'(e.mvd);
        if (first_new_velocity_o !== e.nv0 || second_new_velocity_o !== e.nv1 ||
            first_move_o !== e.mv0 || second_move_o !== e.mv1 ||
            impulse_applied_o !== e.imp || moved_o !== e.mvd) begin
          $display("%0t: mismatch exp v0=%h v1=%h m0=%h m1=%h imp=%b mv=%b", $realtime,
                   e.nv0, e.nv1, e.mv0, e.mv1, e.imp, e.mvd);
          $display("%0t:          act v0=%h v1=%h m0=%h m1=%h imp=%b mv=%b", $realtime,
                   first_new_velocity_o, second_new_velocity_o, first_move_o,
                   second_move_o, impulse_applied_o, moved_o);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > 400000) begin
      $display("Timeout with %0d results outstanding", expected_outcomes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Write one register at the falling edge and wait for the handshake.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_RESTITUTION) restitution_q = val;
    else time_step_q = val[15:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_contacts.size() > 0 || start || expected_outcomes.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  initial begin
    logic [16:0] res_set[5];
    logic [15:0] dt_set[5];
    res_set = '{17'd65536, 17'd0, 17'h1FFFF, 17'd32768, 17'd0};
    dt_set  = '{16'd1092, 16'hFFFF, 16'd0, 16'd1092, 16'd0};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    load_directed();
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_RESTITUTION, ph == 4 ? 17'($urandom_range(0, 65536)) : res_set[ph]);
      write_reg(CFG_TIME_STEP,
                CFG_DATA_W'(ph == 4 ? 16'($urandom) : dt_set[ph]));
      if (ph == 0) load_directed();
      sender_gaps = (ph != 2);
      for (int i = 0; i < N_RANDOM / 5; i++) pending_contacts.push_back(rand_contact());
      drain();
    end
    $display("Resolved %0d contacts over five register settings: %0d impulses, %0d moves",
             resolved, impulses, moves);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pcr_pkg.sv
rtl/pcr_div.sv
rtl/particle_contact_resolver.sv
rtl/pcr_checker.sv
tb/sv/tb_particle_contact_resolver.sv
